[hw/rtl/kpclk_pkg.sv]
// ============================================================================
// kpclk_pkg
// Shared types and constants for the twelve-hour clock with keypad set and
// part counter.
// ============================================================================
package kpclk_pkg;

    // sub-second ticks per second
    localparam logic [4:0] TICKS_PER_SECOND = 5'd10;

    // event kinds
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_KEY  = 2'd1;
    localparam logic [1:0] CMD_PART = 2'd2;

    // keypad codes
    localparam logic [3:0] KEY_MODE    = 4'd15;
    localparam logic [3:0] DIGIT_LIMIT = 4'd10;

    // setting modes
    localparam logic [2:0] MODE_RUN   = 3'd0;
    localparam logic [2:0] MODE_HOURS = 3'd1;
    localparam logic [2:0] MODE_MINS  = 3'd2;
    localparam logic [2:0] MODE_SECS  = 3'd3;
    localparam logic [2:0] MODE_LIMIT = 3'd4;

    // wrap points
    localparam logic [6:0] SIXTY_WRAP  = 7'd60;
    localparam logic [4:0] HOUR_WRAP   = 5'd13;
    localparam logic [6:0] HOUR_ENTRY  = 7'd13;

    // clock and keypad state
    typedef struct packed {
        logic [3:0] prescale;
        logic [5:0] sec;
        logic [5:0] min;
        logic [3:0] hour;
        logic [2:0] mode;
        logic       digit_index;
        logic [6:0] entry;
        logic [6:0] limit;
        logic [6:0] count;
    } clk_state_t;

    // one input request
    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] key_code;
    } clk_event_t;

endpackage

[hw/rtl/kpclk_step.sv]
// ============================================================================
// kpclk_step
// Next-state logic: applies one event (tick, key press or part pulse) to the
// current clock, keypad and counter state.
// ============================================================================
module kpclk_step (
    input  kpclk_pkg::clk_state_t cur,
    input  kpclk_pkg::clk_event_t ev,
    output kpclk_pkg::clk_state_t nxt
);

    logic [4:0] pre_sum;
    logic [6:0] sec_sum;
    logic [6:0] min_sum;
    logic [4:0] hour_sum;
    logic [3:0] mode_sum;
    logic [6:0] digit_x10;
    logic [6:0] entry_new;
    logic [6:0] limit_new;
    logic [6:0] count_sum;

    // candidate sums
    always_comb
    begin
        pre_sum   = {1'b0, cur.prescale} + 5'd1;
        sec_sum   = {1'b0, cur.sec} + 7'd1;
        min_sum   = {1'b0, cur.min} + 7'd1;
        hour_sum  = {1'b0, cur.hour} + 5'd1;
        mode_sum  = {1'b0, cur.mode} + 4'd1;
        digit_x10 = {ev.key_code, 3'b000} + {2'b00, ev.key_code, 1'b0};
        entry_new = cur.digit_index ? (cur.entry + {3'b000, ev.key_code}) : digit_x10;
        limit_new = cur.digit_index ? (cur.limit + {3'b000, ev.key_code}) : digit_x10;
        count_sum = cur.count + 7'd1;
    end

    // event handling and count limit check
    always_comb
    begin
        nxt = cur;
        case (ev.cmd)
            kpclk_pkg::CMD_TICK:
            begin
                if (pre_sum >= kpclk_pkg::TICKS_PER_SECOND)
                begin
                    nxt.prescale = 4'(pre_sum - kpclk_pkg::TICKS_PER_SECOND);
                    if (sec_sum >= kpclk_pkg::SIXTY_WRAP)
                    begin
                        nxt.sec = 6'd0;
                        if (min_sum >= kpclk_pkg::SIXTY_WRAP)
                        begin
                            nxt.min  = 6'd0;
                            nxt.hour = (hour_sum >= kpclk_pkg::HOUR_WRAP) ? 4'd1
                                                                          : hour_sum[3:0];
                        end
                        else
                        begin
                            nxt.min = min_sum[5:0];
                        end
                    end
                    else
                    begin
                        nxt.sec = sec_sum[5:0];
                    end
                end
                else
                begin
                    nxt.prescale = pre_sum[3:0];
                end
            end
            kpclk_pkg::CMD_KEY:
            begin
                if (ev.key_code == kpclk_pkg::KEY_MODE)
                begin
                    nxt.mode        = (mode_sum > {1'b0, kpclk_pkg::MODE_LIMIT})
                                      ? kpclk_pkg::MODE_RUN : mode_sum[2:0];
                    nxt.digit_index = 1'b0;
                end
                else if (ev.key_code < kpclk_pkg::DIGIT_LIMIT)
                begin
                    nxt.entry       = entry_new;
                    nxt.digit_index = ~cur.digit_index;
                    if (cur.mode == kpclk_pkg::MODE_LIMIT)
                    begin
                        nxt.limit = limit_new;
                    end
                    // out-of-range entry resets the field and the digit index
                    case (cur.mode)
                        kpclk_pkg::MODE_HOURS:
                        begin
                            if (entry_new >= kpclk_pkg::HOUR_ENTRY)
                            begin
                                nxt.hour        = 4'd1;
                                nxt.digit_index = 1'b0;
                            end
                            else
                            begin
                                nxt.hour = entry_new[3:0];
                            end
                        end
                        kpclk_pkg::MODE_MINS:
                        begin
                            if (entry_new >= kpclk_pkg::SIXTY_WRAP)
                            begin
                                nxt.min         = 6'd0;
                                nxt.digit_index = 1'b0;
                            end
                            else
                            begin
                                nxt.min = entry_new[5:0];
                            end
                        end
                        kpclk_pkg::MODE_SECS:
                        begin
                            if (entry_new >= kpclk_pkg::SIXTY_WRAP)
                            begin
                                nxt.sec         = 6'd0;
                                nxt.digit_index = 1'b0;
                            end
                            else
                            begin
                                nxt.sec = entry_new[5:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            kpclk_pkg::CMD_PART:
            begin
                nxt.count = count_sum;
            end
            default:
            begin
            end
        endcase

        if (nxt.count > nxt.limit)
        begin
            nxt.count = 7'd1;
        end
    end

endmodule

[hw/rtl/keypad_set_clock_with_part_counter.sv]
// ============================================================================
// keypad_set_clock_with_part_counter
// Twelve-hour clock with keypad setting modes and a part counter that wraps
// back to one above a keyed-in limit.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one event per request: cmd 0 is
//   a sub-second timer tick, 1 a key press (key_code 0-9 digit, 15 mode),
//   2 a part pulse. Output channel (out_valid/out_ready) returns one result
//   per event: hours, minutes, seconds, setting_mode, part_count and
//   limit_value as they stand after that event.
//   An accepted request is held in the input register and is then applied
//   to the state in a single pass; the state registers double as the result
//   register, so out_valid rises when the state registers take the new state.
//   Throughput is one event per clock while out_ready is held high. The input
//   register and the result register form two stages, so a new request is
//   taken while a finished result still waits to be taken.
//   When the receiver stalls, the result holds and the state does not move;
//   one more request fits in the input register before in_ready drops.
//   Reset clears all clock, keypad and counter state to zero (hour reads 0
//   until the first carry or hour entry) and empties both stages.
// ============================================================================
module keypad_set_clock_with_part_counter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [3:0] key_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] hours,
    output logic [5:0] minutes,
    output logic [5:0] seconds,
    output logic [2:0] setting_mode,
    output logic [6:0] part_count,
    output logic [6:0] limit_value
);

    logic                  in_valid_reg;
    kpclk_pkg::clk_event_t ev_reg;
    logic                  out_valid_reg;
    kpclk_pkg::clk_state_t state_reg;
    kpclk_pkg::clk_state_t state_next;
    logic                  advance;

    // handshake control
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ev_reg.cmd      <= cmd;
            ev_reg.key_code <= key_code;
        end
    end

    // next-state logic
    kpclk_step u_step (
        .cur (state_reg),
        .ev  (ev_reg),
        .nxt (state_next)
    );

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result fields
    assign out_valid    = out_valid_reg;
    assign hours        = state_reg.hour;
    assign minutes      = state_reg.min;
    assign seconds      = state_reg.sec;
    assign setting_mode = state_reg.mode;
    assign part_count   = state_reg.count;
    assign limit_value  = state_reg.limit;

endmodule

[hw/rtl/kpclk_checker.sv]
// ============================================================================
// kpclk_checker
// Port-level checks on the clock result channel, bound to the top level.
// ============================================================================
module kpclk_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] hours,
    input logic [5:0] minutes,
    input logic [5:0] seconds,
    input logic [2:0] setting_mode,
    input logic [6:0] part_count,
    input logic [6:0] limit_value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hours) && $stable(minutes)
            && $stable(seconds) && $stable(part_count) && $stable(limit_value))
        else $error("result changed while stalled");

    // time fields stay in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hours <= 4'd12 && minutes < 6'd60 && seconds < 6'd60)
        else $error("time field out of range");

    // count never above limit, except the forced wrap to one
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> part_count <= limit_value || part_count == 7'd1)
        else $error("part count above limit");

    // mode stays within run and limit modes
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> setting_mode <= kpclk_pkg::MODE_LIMIT)
        else $error("setting mode out of range");

    // limit only changes while in limit mode
    a_limit_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) && limit_value != $past(limit_value)
            |-> setting_mode == kpclk_pkg::MODE_LIMIT)
        else $error("limit changed outside limit mode");

endmodule

bind keypad_set_clock_with_part_counter kpclk_checker u_kpclk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .setting_mode (setting_mode),
    .part_count   (part_count),
    .limit_value  (limit_value)
);
